// ===== hw/rtl/fdr_pkg.sv =====
// Shared types, constants and arithmetic steps for the Fresnel reflectance block.
package fdr_pkg;

	localparam logic signed [15:0] ONE_Q14 = 16'sd16384;
	localparam logic [16:0] ONE_Q16 = 17'h10000;
	localparam int SQ_STEPS = 30;
	localparam int DIV_STEPS = 17;
	localparam int QDEPTH = 4;
	localparam int QAW = 2;
	localparam int QCW = 3;

	typedef struct packed {
		logic [14:0] cm;
		logic [15:0] ei;
		logic [15:0] et;
	} fdr_item_t;

	typedef struct packed {
		logic [31:0] rem;
		logic [59:0] rad;
		logic [29:0] root;
	} fdr_sq_t;

	typedef struct packed {
		logic [46:0] rem;
		logic [16:0] low;
		logic [16:0] quo;
	} fdr_div_t;

	// One digit of the square root: take the next two radicand bits.
	function automatic fdr_sq_t sq_step(input fdr_sq_t s);
		logic [33:0] cur;
		logic [33:0] trial;
		fdr_sq_t r;
		cur = {s.rem, s.rad[59:58]};
		trial = {2'b00, s.root, 2'b01};
		r.rad = {s.rad[57:0], 2'b00};
		if (cur >= trial) begin
			r.rem = 32'(cur - trial);
			r.root = {s.root[28:0], 1'b1};
		end else begin
			r.rem = cur[31:0];
			r.root = {s.root[28:0], 1'b0};
		end
		return r;
	endfunction

	// One quotient bit of the restoring divider.
	function automatic fdr_div_t div_step(input fdr_div_t s, input logic [46:0] den);
		logic [47:0] cur;
		fdr_div_t r;
		cur = {s.rem, s.low[16]};
		r.low = {s.low[15:0], 1'b0};
		if (cur >= {1'b0, den}) begin
			r.rem = 47'(cur - {1'b0, den});
			r.quo = {s.quo[15:0], 1'b1};
		end else begin
			r.rem = cur[46:0];
			r.quo = {s.quo[15:0], 1'b0};
		end
		return r;
	endfunction

	// Rounded dividend: num * 2^16 + den / 2.
	function automatic logic [62:0] div_num(input logic [46:0] num, input logic [46:0] den);
		return {num, 16'b0} + {17'b0, den[46:1]};
	endfunction

endpackage

// ===== hw/rtl/fdr_front.sv =====
// Front stage: clamp the cosine, swap indices for a leaving ray, hand off to the queue.
module fdr_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic signed [15:0]  cos_incident,
	input  logic [15:0]         eta_incident,
	input  logic [15:0]         eta_transmit,
	input  logic                q_full,
	output logic                push,
	output fdr_pkg::fdr_item_t  push_item
);
	import fdr_pkg::*;

	logic valid_s1;
	fdr_item_t item_s1;
	logic signed [15:0] cl;
	logic signed [15:0] neg;
	fdr_item_t nxt;

	always_comb begin
		cl = cos_incident;
		if (cos_incident > ONE_Q14) cl = ONE_Q14;
		if (cos_incident < -ONE_Q14) cl = -ONE_Q14;
		neg = -cl;
		if (cl <= 16'sd0) begin
			nxt.cm = neg[14:0];
			nxt.ei = eta_transmit;
			nxt.et = eta_incident;
		end else begin
			nxt.cm = cl[14:0];
			nxt.ei = eta_incident;
			nxt.et = eta_transmit;
		end
	end

	assign in_stall = valid_s1 && q_full;
	assign push = valid_s1 && !q_full;
	assign push_item = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			item_s1 <= nxt;
		end
	end

endmodule

// ===== hw/rtl/fdr_queue.sv =====
// Short queue between the front stage and the arithmetic pipeline.
module fdr_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  fdr_pkg::fdr_item_t  push_item,
	input  logic                pop,
	output logic                full,
	output logic                empty,
	output fdr_pkg::fdr_item_t  head
);
	import fdr_pkg::*;

	fdr_item_t mem_q [QDEPTH];
	logic [QAW-1:0] wp_q;
	logic [QAW-1:0] rp_q;
	logic [QCW-1:0] cnt_q;

	assign full = (cnt_q == QCW'(QDEPTH));
	assign empty = (cnt_q == '0);
	assign head = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop) rp_q <= rp_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= push_item;
		end
	end

endmodule

// ===== hw/rtl/fdr_back.sv =====
// Arithmetic pipeline: squares, Snell test, square root, two ratio dividers, final sum.
module fdr_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	input  fdr_pkg::fdr_item_t  item,
	output logic                take,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [16:0]         reflectance,
	output logic                total_internal
);
	import fdr_pkg::*;

	logic adv;
	assign adv = !out_valid || !out_stall;
	assign take = adv;

	// squares and incident product
	logic        v_s1;
	logic [28:0] cc_s1;
	logic [31:0] eii_s1;
	logic [31:0] ett_s1;
	logic [30:0] a_s1;
	logic [14:0] cm_s1;
	logic [15:0] ei_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (adv) v_s1 <= item_valid;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cc_s1 <= {14'b0, item.cm} * {14'b0, item.cm};
			eii_s1 <= {16'b0, item.ei} * {16'b0, item.ei};
			ett_s1 <= {16'b0, item.et} * {16'b0, item.et};
			a_s1 <= {15'b0, item.ei} * {16'b0, item.cm};
			cm_s1 <= item.cm;
			ei_s1 <= item.ei;
		end
	end

	// U, V and the parallel numerator term
	logic        v_s2;
	logic [59:0] u_s2;
	logic [59:0] vv_s2;
	logic [45:0] p_s2;
	logic [30:0] a_s2;
	logic [15:0] ei_s2;
	logic [28:0] s2v;

	assign s2v = 29'h1000_0000 - cc_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (adv) v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			u_s2 <= {31'b0, s2v} * {28'b0, eii_s1};
			vv_s2 <= {ett_s1, 28'b0};
			p_s2 <= {14'b0, ett_s1} * {31'b0, cm_s1};
			a_s2 <= a_s1;
			ei_s2 <= ei_s1;
		end
	end

	// square root chain; entry 0 also makes the total internal decision
	fdr_sq_t     sq [SQ_STEPS+1];
	logic        sq_v [SQ_STEPS+1];
	logic        sq_tir [SQ_STEPS+1];
	logic [15:0] sq_ei [SQ_STEPS+1];
	logic [30:0] sq_a [SQ_STEPS+1];
	logic [45:0] sq_p [SQ_STEPS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) sq_v[0] <= 1'b0;
		else if (adv) sq_v[0] <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sq_tir[0] <= (u_s2 > vv_s2);
			sq[0].rad <= vv_s2 - u_s2;
			sq[0].rem <= '0;
			sq[0].root <= '0;
			sq_ei[0] <= ei_s2;
			sq_a[0] <= a_s2;
			sq_p[0] <= p_s2;
		end
	end

	for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sq
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) sq_v[k+1] <= 1'b0;
			else if (adv) sq_v[k+1] <= sq_v[k];
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				sq[k+1] <= sq_step(sq[k]);
				sq_tir[k+1] <= sq_tir[k];
				sq_ei[k+1] <= sq_ei[k];
				sq_a[k+1] <= sq_a[k];
				sq_p[k+1] <= sq_p[k];
			end
		end
	end

	// Q = ei * R
	logic        v_s4;
	logic        tir_s4;
	logic [45:0] q_s4;
	logic [45:0] p_s4;
	logic [30:0] a_s4;
	logic [30:0] r_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else if (adv) v_s4 <= sq_v[SQ_STEPS];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			q_s4 <= {30'b0, sq_ei[SQ_STEPS]} * {16'b0, sq[SQ_STEPS].root};
			p_s4 <= sq_p[SQ_STEPS];
			a_s4 <= sq_a[SQ_STEPS];
			r_s4 <= {1'b0, sq[SQ_STEPS].root};
			tir_s4 <= sq_tir[SQ_STEPS];
		end
	end

	// ratio numerators and denominators
	logic        v_s5;
	logic        tir_s5;
	logic        zden_s5;
	logic [46:0] npa_s5;
	logic [46:0] dpa_s5;
	logic [46:0] npe_s5;
	logic [46:0] dpe_s5;
	logic [46:0] dpa_c;
	logic [46:0] dpe_c;

	assign dpa_c = {1'b0, p_s4} + {1'b0, q_s4};
	assign dpe_c = {16'b0, a_s4} + {16'b0, r_s4};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s5 <= 1'b0;
		else if (adv) v_s5 <= v_s4;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			npa_s5 <= (p_s4 >= q_s4) ? {1'b0, p_s4 - q_s4} : {1'b0, q_s4 - p_s4};
			npe_s5 <= (a_s4 >= r_s4) ? {16'b0, a_s4 - r_s4} : {16'b0, r_s4 - a_s4};
			dpa_s5 <= dpa_c;
			dpe_s5 <= dpe_c;
			zden_s5 <= (dpa_c == '0) || (dpe_c == '0);
			tir_s5 <= tir_s4;
		end
	end

	// dividers; entry 0 holds the rounded dividends
	fdr_div_t    dpa [DIV_STEPS+1];
	fdr_div_t    dpe [DIV_STEPS+1];
	logic [46:0] dv_dpa [DIV_STEPS+1];
	logic [46:0] dv_dpe [DIV_STEPS+1];
	logic        dv_v [DIV_STEPS+1];
	logic        dv_tir [DIV_STEPS+1];
	logic        dv_z [DIV_STEPS+1];
	logic [62:0] npa_full;
	logic [62:0] npe_full;

	assign npa_full = div_num(npa_s5, dpa_s5);
	assign npe_full = div_num(npe_s5, dpe_s5);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) dv_v[0] <= 1'b0;
		else if (adv) dv_v[0] <= v_s5;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dpa[0].rem <= {1'b0, npa_full[62:17]};
			dpa[0].low <= npa_full[16:0];
			dpa[0].quo <= '0;
			dpe[0].rem <= {1'b0, npe_full[62:17]};
			dpe[0].low <= npe_full[16:0];
			dpe[0].quo <= '0;
			dv_dpa[0] <= dpa_s5;
			dv_dpe[0] <= dpe_s5;
			dv_tir[0] <= tir_s5;
			dv_z[0] <= zden_s5;
		end
	end

	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) dv_v[k+1] <= 1'b0;
			else if (adv) dv_v[k+1] <= dv_v[k];
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				dpa[k+1] <= div_step(dpa[k], dv_dpa[k]);
				dpe[k+1] <= div_step(dpe[k], dv_dpe[k]);
				dv_dpa[k+1] <= dv_dpa[k];
				dv_dpe[k+1] <= dv_dpe[k];
				dv_tir[k+1] <= dv_tir[k];
				dv_z[k+1] <= dv_z[k];
			end
		end
	end

	// squared ratios
	logic        v_s6;
	logic        tir_s6;
	logic        z_s6;
	logic [33:0] spa_s6;
	logic [33:0] spe_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s6 <= 1'b0;
		else if (adv) v_s6 <= dv_v[DIV_STEPS];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			spa_s6 <= {17'b0, dpa[DIV_STEPS].quo} * {17'b0, dpa[DIV_STEPS].quo};
			spe_s6 <= {17'b0, dpe[DIV_STEPS].quo} * {17'b0, dpe[DIV_STEPS].quo};
			tir_s6 <= dv_tir[DIV_STEPS];
			z_s6 <= dv_z[DIV_STEPS];
		end
	end

	// average, round, saturate
	logic [34:0] sum;
	logic [17:0] avg;

	assign sum = {1'b0, spa_s6} + {1'b0, spe_s6} + 35'h10000;
	assign avg = sum[34:17];

	logic        ovalid_q;
	logic [16:0] refl_q;
	logic        tir_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ovalid_q <= 1'b0;
		else if (adv) ovalid_q <= v_s6;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tir_q <= tir_s6;
			if (tir_s6 || z_s6 || (avg > {1'b0, ONE_Q16})) refl_q <= ONE_Q16;
			else refl_q <= avg[16:0];
		end
	end

	assign out_valid = ovalid_q;
	assign reflectance = refl_q;
	assign total_internal = tir_q;

endmodule

// ===== hw/rtl/fresnel_dielectric_reflectance.sv =====
// Top level of the unpolarized dielectric Fresnel reflectance block.
//
//   channel | ports                                           | direction
//   --------+-------------------------------------------------+----------
//   input   | in_valid, in_stall, cos_incident, eta_incident, | in
//           | eta_transmit                                    |
//   output  | out_valid, out_stall, reflectance,              | out
//           | total_internal                                  |
//
// One transaction per cycle sustained when nothing stalls; the back pipeline
// holds a 30-step square root and two 17-step dividers.
// Reset (arst_n low) clears every valid flag and the queue pointers at once.
// out_stall freezes the back pipeline while out_valid is high; the four-entry
// queue keeps the front accepting until it fills, and in_stall rises only then.
module fresnel_dielectric_reflectance (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [15:0] cos_incident,
	input  logic [15:0]        eta_incident,
	input  logic [15:0]        eta_transmit,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [16:0]        reflectance,
	output logic               total_internal
);
	import fdr_pkg::*;

	logic      push;
	fdr_item_t push_item;
	logic      q_full;
	logic      q_empty;
	fdr_item_t head;
	logic      take;

	// Clamp, swap on a leaving ray, register.
	fdr_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.cos_incident(cos_incident),
		.eta_incident(eta_incident),
		.eta_transmit(eta_transmit),
		.q_full      (q_full),
		.push        (push),
		.push_item   (push_item)
	);

	// Decouple front from back; pop whenever the back pipeline advances and the queue is not empty.
	fdr_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_item(push_item),
		.pop      (take && !q_empty),
		.full     (q_full),
		.empty    (q_empty),
		.head     (head)
	);

	// Arithmetic pipeline, advancing as one unit unless the output is held.
	fdr_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_valid    (!q_empty),
		.item          (head),
		.take          (take),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.reflectance   (reflectance),
		.total_internal(total_internal)
	);

	// Total internal reflection always reports full reflectance.
	a_tir_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && total_internal |-> reflectance == ONE_Q16)
		else $error("total internal result without full reflectance");

	// Reflectance never exceeds one.
	a_refl_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> reflectance <= ONE_Q16)
		else $error("reflectance above one");

	// The front only stalls on a full queue, which needs a held output.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> q_full)
		else $error("input stalled with room in the queue");

endmodule
